### sv/tpu_pkg.sv
// Types and constants shared by the tracker pattern unpacker modules.
`timescale 1ns / 1ps
package tpu_pkg;

	localparam int TRK_W  = 6;
	localparam int TRACKS = 1 << TRK_W;

	localparam logic [7:0] VOL_DEFAULT = 8'd255;
	localparam logic [2:0] HDR_ROWS_LO = 3'd2;
	localparam logic [2:0] HDR_ROWS_HI = 3'd3;
	localparam logic [2:0] HDR_LAST    = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HEADER,
		PH_CHN,
		PH_MASK,
		PH_NOTE,
		PH_SAMPLE,
		PH_VOLUME,
		PH_EFFECT,
		PH_EFFVAL
	} phase_t;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] sample;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] param;
	} cell_t;

	typedef struct packed {
		logic [7:0] mask;
		cell_t      val;
	} mem_row_t;

	typedef struct packed {
		logic             has_cell;
		logic             pattern_end;
		logic [15:0]      row_index;
		logic [TRK_W-1:0] channel;
		cell_t            body;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [TRK_W-1:0] addr;
		mem_row_t         row;
	} mem_wr_t;

	localparam cell_t CELL_CLEAR = '{note: 8'd0, sample: 8'd0, volume: VOL_DEFAULT,
		effect: 8'd0, param: 8'd0};

endpackage

### sv/tracker_pattern_unpacker_top.sv
// Top level of the tracker pattern unpacker: input stage, track memory, result register.
`timescale 1ns / 1ps
// Takes one pattern word per cycle and gives at most one result per word, held in the
// result register until the consumer takes it. The word goes into an
// input register while the 64-entry track memory is read at the track that the word
// would select; the parser then decodes the word against that row and the result
// register holds the cell for the consumer, so a new word is taken in every cycle
// unless a result waits with the consumer stalled. A row written by the word just
// before is forwarded. Per-track valid flags clear the whole memory at once when
// pattern_start is seen, so there is no clearing pass.
module tracker_pattern_unpacker_top #(
	parameter int CHANNELS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       pattern_start,
	output logic       cell_valid,
	input  logic       cell_ready,
	output logic       has_cell,
	output logic       pattern_end,
	output logic [15:0] row_index,
	output logic [5:0] channel,
	output logic [7:0] note_value,
	output logic [7:0] sample_number,
	output logic [7:0] volume_value,
	output logic [7:0] effect_command,
	output logic [7:0] effect_parameter
);
	import tpu_pkg::*;

	logic             valid_s1, start_s1, byp_s1, in_fire, pfire, res_valid;
	logic [7:0]       data_s1;
	mem_row_t         byp_row_s1, rdata, row_src;
	logic [TRK_W-1:0] rd_addr, trk_s1;
	logic [TRACKS-1:0] tvalid_q;
	result_t          res, res_q;
	mem_wr_t          wr;
	logic             out_valid_q;

	assign pfire      = valid_s1 && (!out_valid_q || cell_ready);
	assign byte_ready = !valid_s1 || pfire;
	assign in_fire    = byte_valid && byte_ready;
	assign rd_addr    = TRK_W'(data_byte - 8'd1);
	assign trk_s1     = TRK_W'(data_s1 - 8'd1);

	tpu_ram #(
		.WIDTH($bits(mem_row_t)),
		.DEPTH(TRACKS)
	) u_mem (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.addr),
		.wdata(wr.row),
		.re   (in_fire),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		if (byp_s1) begin
			row_src = byp_row_s1;
		end else if (tvalid_q[trk_s1]) begin
			row_src = rdata;
		end else begin
			row_src = '0;
		end
	end

	tpu_parse #(
		.CHANNELS(CHANNELS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (pfire),
		.data     (data_s1),
		.start    (start_s1),
		.row_src  (row_src),
		.res_valid(res_valid),
		.res      (res),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			byp_s1      <= 1'b0;
			tvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				byp_s1   <= wr.en && (wr.addr == rd_addr);
			end else if (pfire) begin
				valid_s1 <= 1'b0;
			end
			if (pfire && start_s1) begin
				tvalid_q <= '0;
			end else if (wr.en) begin
				tvalid_q[wr.addr] <= 1'b1;
			end
			if (pfire) begin
				out_valid_q <= res_valid;
			end else if (cell_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1    <= data_byte;
			start_s1   <= pattern_start;
			byp_row_s1 <= wr.row;
		end
		if (pfire) begin
			res_q <= res;
		end
	end

	assign cell_valid       = out_valid_q;
	assign has_cell         = res_q.has_cell;
	assign pattern_end      = res_q.pattern_end;
	assign row_index        = res_q.row_index;
	assign channel          = res_q.channel;
	assign note_value       = res_q.body.note;
	assign sample_number    = res_q.body.sample;
	assign volume_value     = res_q.body.volume;
	assign effect_command   = res_q.body.effect;
	assign effect_parameter = res_q.body.param;

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> byte_ready)
		else $error("input stalled with an empty result register");

	a_clear_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		pfire && start_s1 |=> tvalid_q == '0)
		else $error("track memory not cleared at pattern start");

	a_no_write_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		pfire && start_s1 |-> !wr.en)
		else $error("track memory written on a header word");

endmodule

### sv/tpu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tpu_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/tpu_parse.sv
// Pattern parser: header, channel/mask/field decode, recall and per-track store.
`timescale 1ns / 1ps
module tpu_parse #(
	parameter int CHANNELS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data,
	input  logic              start,
	input  tpu_pkg::mem_row_t row_src,
	output logic              res_valid,
	output tpu_pkg::result_t  res,
	output tpu_pkg::mem_wr_t  wr
);
	import tpu_pkg::*;

	localparam int EW = $clog2(CHANNELS + 1);

	phase_t           phase_q, phase_d, ph;
	logic [2:0]       hpos_q, hpos_d, hpos;
	logic [15:0]      rows_q, rows_d, rows;
	logic [15:0]      rowcnt_q, rowcnt_d, rowcnt;
	logic [EW-1:0]    ent_q, ent_d, ent, ent_inc;
	logic [TRK_W-1:0] trk_q, trk_d, trk_c;
	logic [7:0]       mask_q, mask_d, mask_c;
	cell_t            cell_q, cell_d, cell_c, fin;
	mem_row_t         mrow_q, mrow_d, mrow_c, row_new;
	logic [3:0]       first, hits;
	logic             do_adv, finish, end_row, pend, hdr_done;
	logic [16:0]      next_row;
	phase_t           adv_phase;

	// a pattern start restarts the header in the same word
	assign ph     = start ? PH_HEADER : phase_q;
	assign hpos   = start ? 3'd0 : hpos_q;
	assign rows   = start ? 16'd0 : rows_q;
	assign rowcnt = start ? 16'd0 : rowcnt_q;
	assign ent    = start ? EW'(0) : ent_q;

	assign trk_c  = (ph == PH_CHN) ? TRK_W'(data - 8'd1) : trk_q;
	assign mrow_c = (ph == PH_CHN) ? row_src : mrow_q;

	always_comb begin
		mask_c = mask_q;
		cell_c = cell_q;
		first  = 4'b0000;
		do_adv = 1'b0;
		case (ph)
			PH_CHN: begin
				mask_c = row_src.mask;
				cell_c = CELL_CLEAR;
				first  = 4'b1111;
				do_adv = (data != 8'd0) && !data[7];
			end
			PH_MASK: begin
				mask_c = data;
				first  = 4'b1111;
				do_adv = 1'b1;
			end
			PH_NOTE: begin
				cell_c.note = data + 8'd1;
				first       = 4'b1110;
				do_adv      = 1'b1;
			end
			PH_SAMPLE: begin
				cell_c.sample = data;
				first         = 4'b1100;
				do_adv        = 1'b1;
			end
			PH_VOLUME: begin
				cell_c.volume = data;
				first         = 4'b1000;
				do_adv        = 1'b1;
			end
			PH_EFFECT: cell_c.effect = data;
			PH_EFFVAL: cell_c.param  = data;
			default: ;
		endcase
	end

	assign hits = mask_c[3:0] & first;

	always_comb begin
		if (hits[0]) begin
			adv_phase = PH_NOTE;
		end else if (hits[1]) begin
			adv_phase = PH_SAMPLE;
		end else if (hits[2]) begin
			adv_phase = PH_VOLUME;
		end else begin
			adv_phase = PH_EFFECT;
		end
	end

	assign finish = (do_adv && (hits == 4'b0000)) || (ph == PH_EFFVAL);

	// recall first, then store what was read
	always_comb begin
		fin = cell_c;
		if (mask_c[4]) fin.note   = mrow_c.val.note;
		if (mask_c[5]) fin.sample = mrow_c.val.sample;
		if (mask_c[6]) fin.volume = mrow_c.val.volume;
		if (mask_c[7]) begin
			fin.effect = mrow_c.val.effect;
			fin.param  = mrow_c.val.param;
		end
		row_new      = mrow_c;
		row_new.mask = (ph == PH_MASK) ? data : mrow_c.mask;
		if (mask_c[0]) row_new.val.note   = fin.note;
		if (mask_c[1]) row_new.val.sample = fin.sample;
		if (mask_c[2]) row_new.val.volume = fin.volume;
		if (mask_c[3]) begin
			row_new.val.effect = fin.effect;
			row_new.val.param  = fin.param;
		end
	end

	assign ent_inc  = ent + EW'(1);
	assign end_row  = ((ph == PH_CHN) && (data == 8'd0)) ||
		(finish && (ent_inc == EW'(CHANNELS)));
	assign next_row = {1'b0, rowcnt} + 17'd1;
	assign pend     = next_row >= {1'b0, rows};
	assign hdr_done = (ph == PH_HEADER) && (hpos == HDR_LAST);

	// next state
	always_comb begin
		phase_d  = ph;
		hpos_d   = hpos;
		rows_d   = rows;
		rowcnt_d = rowcnt;
		ent_d    = ent;
		trk_d    = trk_c;
		mask_d   = mask_q;
		cell_d   = cell_c;
		mrow_d   = mrow_q;
		unique case (ph)
			PH_IDLE: ;
			PH_HEADER: begin
				if (hpos == HDR_ROWS_LO) rows_d[7:0]  = data;
				if (hpos == HDR_ROWS_HI) rows_d[15:8] = data;
				if (hpos == HDR_LAST) begin
					hpos_d   = 3'd0;
					rowcnt_d = 16'd0;
					ent_d    = EW'(0);
					phase_d  = (rows == 16'd0) ? PH_IDLE : PH_CHN;
				end else begin
					hpos_d = hpos + 3'd1;
				end
			end
			PH_CHN: begin
				if (data != 8'd0) begin
					mrow_d  = row_src;
					phase_d = PH_MASK;
					if (!data[7]) mask_d = row_src.mask;
				end
			end
			PH_MASK: begin
				mask_d      = data;
				mrow_d.mask = data;
			end
			PH_EFFECT: phase_d = PH_EFFVAL;
			PH_NOTE, PH_SAMPLE, PH_VOLUME, PH_EFFVAL: ;
			default: phase_d = PH_IDLE;
		endcase
		if (do_adv && !finish) phase_d = adv_phase;
		if (end_row) begin
			ent_d    = EW'(0);
			rowcnt_d = next_row[15:0];
			phase_d  = pend ? PH_IDLE : PH_CHN;
		end else if (finish) begin
			ent_d   = ent_inc;
			phase_d = PH_CHN;
		end
	end

	// outputs
	always_comb begin
		res_valid = finish || (hdr_done && (rows == 16'd0)) || (end_row && pend);
		res       = '0;
		if (finish) begin
			res.has_cell  = 1'b1;
			res.row_index = rowcnt;
			res.channel   = trk_c;
			res.body      = fin;
		end
		res.pattern_end = (hdr_done && (rows == 16'd0)) || (end_row && pend);
		wr.en   = fire && finish;
		wr.addr = trk_c;
		wr.row  = row_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hpos_q   <= 3'd0;
			rows_q   <= 16'd0;
			rowcnt_q <= 16'd0;
			ent_q    <= EW'(0);
			trk_q    <= '0;
			mask_q   <= 8'd0;
			cell_q   <= CELL_CLEAR;
		end else if (fire) begin
			phase_q  <= phase_d;
			hpos_q   <= hpos_d;
			rows_q   <= rows_d;
			rowcnt_q <= rowcnt_d;
			ent_q    <= ent_d;
			trk_q    <= trk_d;
			mask_q   <= mask_d;
			cell_q   <= cell_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mrow_q <= mrow_d;
		end
	end

	a_end_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_cell |-> res.pattern_end)
		else $error("result with neither cell nor pattern end");

	a_wr_on_cell: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> res_valid && res.has_cell)
		else $error("track memory written without a completed cell");

	a_ent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ent_q < EW'(CHANNELS))
		else $error("row entry count out of range");

endmodule
